[src/psms_pkg.sv]
// ----------------------------------------------------------------------------
// psms_pkg
// Shared constants and types for the periodic sphere mass statistics block.
// ----------------------------------------------------------------------------
package psms_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int MASS_BITS_DEF  = 32;
   localparam int INDEX_BITS_DEF = 20;

   localparam int RSQ_BITS   = 48;
   localparam int SUM_BITS   = 52;
   localparam int COUNT_BITS = 21;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_SIZE        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTRE_X        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTRE_Y        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTRE_Z        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS_SQ       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INNER_RADIUS_SQ = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MASS_CUT        = 3'd6;

   typedef logic [SUM_BITS-1:0]   sum_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [RSQ_BITS-1:0]   rsq_type;

endpackage

[src/periodic_sphere_mass_stats.sv]
// ----------------------------------------------------------------------------
// periodic_sphere_mass_stats
// Streams point objects against a sphere in a periodic box and reports the
// heaviest inner object, member count and member mass once per pass.
// ----------------------------------------------------------------------------
// The block takes one object per clock cycle and gives one result once the
// tlast item leaves the pipeline. Objects pass through five register stages:
// input, per-axis difference, minimum-image wrap, squaring (one multiplier per
// axis), and the radius compare; the running maximum and saturating sums are
// registered behind them. While a result waits on rsp_tready the whole
// pipeline holds. Configuration must be written through the csr_ port only
// while no pass is in flight (not enforced here); an index above 6 is ignored.
module periodic_sphere_mass_stats
   import psms_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int MASS_BITS  = MASS_BITS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic clock,
   input  logic reset,

   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // pos_x, pos_y, pos_z, mass, zero fill
   input  logic [((3*COORD_BITS+MASS_BITS+7)/8)*8-1:0]  req_tdata,
   input  logic                                         req_tlast,

   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // heaviest_found, heaviest_mass, heaviest_x, heaviest_y, heaviest_z,
   // heaviest_index, total_mass, member_count, count_saturated, zero fill
   output logic [((2+MASS_BITS+3*COORD_BITS+INDEX_BITS+SUM_BITS+COUNT_BITS+7)/8)*8-1:0]
                                                        rsp_tdata,

   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]                    csr_index,
   input  logic [CSR_DATA_BITS-1:0]                     csr_data
);

   localparam int C          = COORD_BITS;
   localparam int M          = MASS_BITS;
   localparam int I          = INDEX_BITS;
   localparam int R2_BITS    = 2*C + 2;
   localparam int CMP_BITS   = (R2_BITS > RSQ_BITS) ? R2_BITS : RSQ_BITS;
   localparam int OUT_BITS   = 2 + M + 3*C + I + SUM_BITS + COUNT_BITS;
   localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

   localparam int O_FOUND = 0;
   localparam int O_MASS  = 1;
   localparam int O_X     = O_MASS + M;
   localparam int O_IDX   = O_X + 3*C;
   localparam int O_SUM   = O_IDX + I;
   localparam int O_CNT   = O_SUM + SUM_BITS;
   localparam int O_SAT   = O_CNT + COUNT_BITS;

   // configuration
   logic [C-1:0] box_ff;
   logic [C-1:0] centre_ff [3];
   rsq_type      radius_sq_ff;
   rsq_type      inner_sq_ff;
   logic [M-1:0] mass_cut_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff       <= '1;
         centre_ff[0] <= '0;
         centre_ff[1] <= '0;
         centre_ff[2] <= '0;
         radius_sq_ff <= '0;
         inner_sq_ff  <= '0;
         mass_cut_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOX_SIZE:        box_ff       <= csr_data[C-1:0];
            CSR_CENTRE_X:        centre_ff[0] <= csr_data[C-1:0];
            CSR_CENTRE_Y:        centre_ff[1] <= csr_data[C-1:0];
            CSR_CENTRE_Z:        centre_ff[2] <= csr_data[C-1:0];
            CSR_RADIUS_SQ:       radius_sq_ff <= csr_data[RSQ_BITS-1:0];
            CSR_INNER_RADIUS_SQ: inner_sq_ff  <= csr_data[RSQ_BITS-1:0];
            CSR_MASS_CUT:        mass_cut_ff  <= csr_data[M-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic rsp_valid_ff;
   logic adv;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_last_ff,  s2_last_ff,  s3_last_ff,  s4_last_ff,  s5_last_ff;
   logic [M-1:0] mass_s1_ff, mass_s2_ff, mass_s3_ff, mass_s4_ff, mass_s5_ff;
   logic [C-1:0] pos_s1_ff [3];
   logic [C-1:0] pos_s2_ff [3];
   logic [C-1:0] pos_s3_ff [3];
   logic [C-1:0] pos_s4_ff [3];
   logic [C-1:0] pos_s5_ff [3];
   logic signed [C:0]          d_s2_ff  [3];
   logic signed [C+1:0]        w_s3_ff  [3];
   logic [2*C-1:0]             sq_s4_ff [3];
   logic inside_s5_ff, inner_s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff <= req_tlast;
         s2_last_ff <= s1_last_ff;
         s3_last_ff <= s2_last_ff;
         s4_last_ff <= s3_last_ff;
         s5_last_ff <= s4_last_ff;
         mass_s1_ff <= req_tdata[3*C +: M];
         mass_s2_ff <= mass_s1_ff;
         mass_s3_ff <= mass_s2_ff;
         mass_s4_ff <= mass_s3_ff;
         mass_s5_ff <= mass_s4_ff;
      end
   end

   genvar a;
   generate
      for (a = 0; a < 3; a++) begin : g_axis
         logic signed [C+1:0]   d_ext;
         logic signed [C+1:0]   twice;
         logic signed [C+1:0]   box_ext;
         logic signed [C+1:0]   w_in;
         logic signed [2*C+3:0] prod;

         assign d_ext   = {d_s2_ff[a][C], d_s2_ff[a]};
         assign twice   = d_ext <<< 1;
         assign box_ext = $signed({2'b00, box_ff});
         assign w_in    = (twice > box_ext)  ? d_ext - box_ext :
                          (twice < -box_ext) ? d_ext + box_ext : d_ext;
         assign prod    = w_s3_ff[a] * w_s3_ff[a];

         always_ff @(posedge clock) begin
            if (adv) begin
               pos_s1_ff[a] <= req_tdata[a*C +: C];
               pos_s2_ff[a] <= pos_s1_ff[a];
               pos_s3_ff[a] <= pos_s2_ff[a];
               pos_s4_ff[a] <= pos_s3_ff[a];
               pos_s5_ff[a] <= pos_s4_ff[a];
               d_s2_ff[a]   <= $signed({1'b0, pos_s1_ff[a]}) -
                               $signed({1'b0, centre_ff[a]});
               w_s3_ff[a]   <= w_in;
               sq_s4_ff[a]  <= prod[2*C-1:0];
            end
         end
      end
   endgenerate

   // squared distance, never beyond 2C+2 bits so no saturation needed
   logic [R2_BITS-1:0]  r2;
   logic [CMP_BITS-1:0] r2_cmp, rad_cmp, inner_cmp;

   assign r2        = R2_BITS'(sq_s4_ff[0]) + R2_BITS'(sq_s4_ff[1]) +
                      R2_BITS'(sq_s4_ff[2]);
   assign r2_cmp    = CMP_BITS'(r2);
   assign rad_cmp   = CMP_BITS'(radius_sq_ff);
   assign inner_cmp = CMP_BITS'(inner_sq_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         inside_s5_ff <= r2_cmp < rad_cmp;
         inner_s5_ff  <= r2_cmp < inner_cmp;
      end
   end

   // pass accumulators
   logic [M-1:0] best_mass_ff, best_mass_in;
   logic [C-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in, best_z_ff, best_z_in;
   logic [I-1:0] best_index_ff, best_index_in;
   logic         best_valid_ff, best_valid_in;
   sum_type      mass_sum_ff, mass_sum_in;
   count_type    members_ff, members_in;
   logic [I-1:0] item_index_ff, item_index_in;
   logic         saturated_ff, saturated_in;
   logic [SUM_BITS:0] sum_ext;
   logic         step;

   assign step    = s5_valid_ff && adv;
   assign sum_ext = {1'b0, mass_sum_ff} + (SUM_BITS+1)'(mass_s5_ff);

   always_comb begin
      best_mass_in  = best_mass_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      best_z_in     = best_z_ff;
      best_index_in = best_index_ff;
      best_valid_in = best_valid_ff;
      mass_sum_in   = mass_sum_ff;
      members_in    = members_ff;
      item_index_in = item_index_ff;
      saturated_in  = saturated_ff;
      if (inside_s5_ff) begin
         if (inner_s5_ff && mass_s5_ff >= best_mass_ff) begin
            best_mass_in  = mass_s5_ff;
            best_x_in     = pos_s5_ff[0];
            best_y_in     = pos_s5_ff[1];
            best_z_in     = pos_s5_ff[2];
            best_index_in = item_index_ff;
            best_valid_in = 1'b1;
         end
         if (mass_s5_ff >= mass_cut_ff) begin
            if (sum_ext[SUM_BITS]) begin
               mass_sum_in  = '1;
               saturated_in = 1'b1;
            end else begin
               mass_sum_in = sum_ext[SUM_BITS-1:0];
            end
            if (&members_ff) begin
               saturated_in = 1'b1;
            end else begin
               members_in = members_ff + 1'b1;
            end
         end
      end
      if (!s5_last_ff) begin
         if (&item_index_ff) begin
            saturated_in = 1'b1;
         end else begin
            item_index_in = item_index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && s5_last_ff)) begin
         best_mass_ff  <= '0;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         best_z_ff     <= '0;
         best_index_ff <= '0;
         best_valid_ff <= 1'b0;
         mass_sum_ff   <= '0;
         members_ff    <= '0;
         item_index_ff <= '0;
         saturated_ff  <= 1'b0;
      end else if (step) begin
         best_mass_ff  <= best_mass_in;
         best_x_ff     <= best_x_in;
         best_y_ff     <= best_y_in;
         best_z_ff     <= best_z_in;
         best_index_ff <= best_index_in;
         best_valid_ff <= best_valid_in;
         mass_sum_ff   <= mass_sum_in;
         members_ff    <= members_in;
         item_index_ff <= item_index_in;
         saturated_ff  <= saturated_in;
      end
   end

   // result register
   logic [OUT_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in                       = '0;
      rsp_data_in[O_FOUND]              = best_valid_in;
      rsp_data_in[O_MASS +: M]          = best_mass_in;
      rsp_data_in[O_X +: C]             = best_x_in;
      rsp_data_in[O_X + C +: C]         = best_y_in;
      rsp_data_in[O_X + 2*C +: C]       = best_z_in;
      rsp_data_in[O_IDX +: I]           = best_index_in;
      rsp_data_in[O_SUM +: SUM_BITS]    = mass_sum_in;
      rsp_data_in[O_CNT +: COUNT_BITS]  = members_in;
      rsp_data_in[O_SAT]                = saturated_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && s5_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && s5_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      step && s5_last_ff |=> rsp_tvalid)
      else $error("last item did not produce a result");

   a_no_members_no_mass: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[O_CNT +: COUNT_BITS] == '0
      |-> rsp_tdata[O_SUM +: SUM_BITS] == '0)
      else $error("member mass without members");

   a_empty_best_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[O_FOUND]
      |-> rsp_tdata[O_MASS +: M] == '0 && rsp_tdata[O_IDX +: I] == '0 &&
          rsp_tdata[O_X +: 3*C] == '0)
      else $error("heaviest fields set without a heaviest object");

endmodule
